/* hdl/kns_pkg.sv */
// ----------------------------------------------------------------------------
// kns_pkg
// Shared types and constants for the k-nearest stencil selector.
// ----------------------------------------------------------------------------
package kns_pkg;

  localparam int MAX_NODES_DEF   = 1024;
  localparam int MAX_STENCIL_DEF = 32;
  localparam int COORD_BITS_DEF  = 16;

  localparam int ACTION_W = 2;
  localparam int RANK_W   = 5;
  localparam int NODE_W   = 10;
  localparam int DIST_W   = 34;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 6;

  localparam logic [CFG_W-1:0] STENCIL_RESET = 6'd16;

  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_ERROR = 2'd2
  } cmd_t;

endpackage

/* hdl/kns_front.sv */
// ----------------------------------------------------------------------------
// kns_front
// Accepts transactions, keeps the node store, classifies queries and hands
// commands to the back end through a two-entry queue.
// ----------------------------------------------------------------------------
module kns_front
  import kns_pkg::*;
#(
  parameter int MAX_NODES  = MAX_NODES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IDX_W     = $clog2(MAX_NODES),
  localparam int CNT_W     = $clog2(MAX_NODES + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [ACTION_W-1:0]          action,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  input  logic [NODE_W-1:0]            query_node,
  // command queue head
  output logic                         cmd_valid,
  output cmd_t                         cmd_kind,
  output logic [STATUS_W-1:0]          cmd_status,
  output logic [IDX_W-1:0]             cmd_center,
  output logic [CNT_W-1:0]             cmd_count,
  input  logic                         cmd_pop,
  input  logic                         back_busy,
  // store read port for the back end
  input  logic [IDX_W-1:0]             rd_addr,
  output logic [3*COORD_BITS-1:0]      rd_data
);

  logic [3*COORD_BITS-1:0] store [MAX_NODES];
  logic [CNT_W-1:0]        node_count;
  logic [1:0]              q_used;

  // queue of depth two: entry 0 is the head
  cmd_t                q_kind   [2];
  logic [STATUS_W-1:0] q_status [2];
  logic [IDX_W-1:0]    q_center [2];
  logic [CNT_W-1:0]    q_count  [2];

  logic                accept;
  logic                do_push;
  cmd_t                new_kind;
  logic [STATUS_W-1:0] new_status;
  logic [CNT_W-1:0]    qn_ext;

  // store writes must not race a running scan
  assign full    = (q_used != 2'd0) || back_busy;
  assign accept  = push && !full;
  assign qn_ext  = CNT_W'(query_node);

  always_comb begin
    new_kind   = CMD_NONE;
    new_status = ST_OK;
    if (action == ACT_QUERY) begin
      if (node_count == '0) begin
        new_kind   = CMD_ERROR;
        new_status = ST_EMPTY;
      end else if (qn_ext >= node_count || (NODE_W > IDX_W &&
                   (query_node >> IDX_W) != '0)) begin
        new_kind   = CMD_ERROR;
        new_status = ST_RANGE;
      end else begin
        new_kind = CMD_QUERY;
      end
    end
  end

  assign do_push = accept && new_kind != CMD_NONE;

  always_ff @(posedge clk) begin
    if (accept && action == ACT_APPEND && node_count < CNT_W'(MAX_NODES)) begin
      store[node_count[IDX_W-1:0]] <= {coord_x, coord_y, coord_z};
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
    end else if (accept) begin
      if (action == ACT_CLEAR) begin
        node_count <= '0;
      end else if (action == ACT_APPEND && node_count < CNT_W'(MAX_NODES)) begin
        node_count <= node_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_used <= '0;
    end else begin
      q_used <= q_used + {1'b0, do_push} - {1'b0, cmd_pop && cmd_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd_valid) begin
      q_kind[0]   <= q_kind[1];
      q_status[0] <= q_status[1];
      q_center[0] <= q_center[1];
      q_count[0]  <= q_count[1];
    end
    if (do_push) begin
      if (q_used == 2'd0 || (q_used == 2'd1 && cmd_pop)) begin
        q_kind[0]   <= new_kind;
        q_status[0] <= new_status;
        q_center[0] <= IDX_W'(query_node);
        q_count[0]  <= node_count;
      end else begin
        q_kind[1]   <= new_kind;
        q_status[1] <= new_status;
        q_center[1] <= IDX_W'(query_node);
        q_count[1]  <= node_count;
      end
    end
  end

  assign cmd_valid  = q_used != 2'd0;
  assign cmd_kind   = q_kind[0];
  assign cmd_status = q_status[0];
  assign cmd_center = q_center[0];
  assign cmd_count  = q_count[0];

endmodule

/* hdl/kns_back.sv */
// ----------------------------------------------------------------------------
// kns_back
// Scans the store for a query, keeps a sorted best list by insertion and
// streams the result transactions out through a two-entry output queue.
// ----------------------------------------------------------------------------
module kns_back
  import kns_pkg::*;
#(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int MAX_STENCIL = MAX_STENCIL_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF,
  localparam int IDX_W      = $clog2(MAX_NODES),
  localparam int CNT_W      = $clog2(MAX_NODES + 1),
  localparam int K_W        = $clog2(MAX_STENCIL + 1),
  localparam int SQ_W       = 2 * COORD_BITS + 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [CFG_W-1:0]        stencil_len,
  input  logic                    cmd_valid,
  input  cmd_t                    cmd_kind,
  input  logic [STATUS_W-1:0]     cmd_status,
  input  logic [IDX_W-1:0]        cmd_center,
  input  logic [CNT_W-1:0]        cmd_count,
  output logic                    cmd_pop,
  output logic                    back_busy,
  output logic [IDX_W-1:0]        rd_addr,
  input  logic [3*COORD_BITS-1:0] rd_data,
  output logic                    empty,
  input  logic                    pop,
  output logic [RANK_W-1:0]       neighbour_rank,
  output logic [NODE_W-1:0]       neighbour_node,
  output logic [DIST_W-1:0]       squared_distance,
  output logic [STATUS_W-1:0]     status,
  output logic                    last
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CENTER = 6'b000010,
    S_LOADC  = 6'b000100,
    S_SCAN   = 6'b001000,
    S_EMIT   = 6'b010000,
    S_ERR    = 6'b100000
  } state_t;

  state_t state;

  logic [K_W-1:0]   k;
  logic [K_W-1:0]   filled;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] issue;
  logic [IDX_W-1:0] center;
  logic [COORD_BITS-1:0] cx, cy, cz;
  logic [STATUS_W-1:0] cmd_status_q;

  // pipeline: issue -> read -> squares -> sum -> insert
  logic             v1, v2, v3;
  logic [IDX_W-1:0] j1, j2, j3;
  logic [SQ_W-1:0]  sqx, sqy, sqz;
  logic [SQ_W-1:0]  dsum;

  logic [SQ_W-1:0]  bdist [MAX_STENCIL];
  logic [IDX_W-1:0] bnode [MAX_STENCIL];
  logic [MAX_STENCIL-1:0] lt;

  logic [K_W-1:0]   emit_r;

  // output queue
  logic [1:0]             oq_used;
  logic [RANK_W-1:0]      oq_rank [2];
  logic [NODE_W-1:0]      oq_node [2];
  logic [DIST_W-1:0]      oq_dist [2];
  logic [STATUS_W-1:0]    oq_stat [2];
  logic                   oq_last [2];
  logic                   o_push;
  logic [RANK_W-1:0]      o_rank;
  logic [NODE_W-1:0]      o_node;
  logic [DIST_W-1:0]      o_dist;
  logic [STATUS_W-1:0]    o_stat;
  logic                   o_last;
  logic                   o_pop;

  logic [K_W-1:0]   s_eff;
  logic [CNT_W-1:0] half;

  always_comb begin
    if (stencil_len == '0) begin
      s_eff = K_W'(1);
    end else if (32'(stencil_len) > MAX_STENCIL) begin
      s_eff = K_W'(MAX_STENCIL);
    end else begin
      s_eff = K_W'(stencil_len);
    end
    half = cmd_count >> 1;
  end

  function automatic logic [SQ_W-1:0] sqd(input logic [COORD_BITS-1:0] a,
                                          input logic [COORD_BITS-1:0] b);
    logic signed [COORD_BITS:0] d;
    logic [COORD_BITS:0]        m;
    d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    m = d[COORD_BITS] ? (COORD_BITS+1)'(-d) : d;
    return SQ_W'(m) * SQ_W'(m);
  endfunction

  assign cmd_pop   = (state == S_IDLE) && cmd_valid;
  assign back_busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      filled <= '0;
    end else begin
      v1 <= (state == S_SCAN) && issue < count;
      v2 <= v1;
      v3 <= v2;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            count  <= cmd_count;
            center <= cmd_center;
            filled <= '0;
            if (cmd_kind == CMD_QUERY) begin
              state <= S_CENTER;
              if (CNT_W'(s_eff) > cmd_count) begin
                k <= (half == '0) ? K_W'(1) : K_W'(half);
              end else begin
                k <= s_eff;
              end
            end else begin
              state <= S_ERR;
            end
          end
        end
        S_CENTER: state <= S_LOADC;
        S_LOADC: begin
          {cx, cy, cz} <= rd_data;
          issue <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (issue < count) begin
            issue <= issue + 1'b1;
          end else if (!v1 && !v2 && !v3) begin
            emit_r <= '0;
            state  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (o_push && o_last) begin
            state <= S_IDLE;
          end
          if (o_push) begin
            emit_r <= emit_r + 1'b1;
          end
        end
        S_ERR: begin
          if (o_push) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (v3 && state == S_SCAN) begin
        if (filled < k) begin
          filled <= filled + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_status_q <= (state == S_IDLE) ? cmd_status : cmd_status_q;
  end

  assign rd_addr = (state == S_SCAN) ? issue[IDX_W-1:0] : center;

  always_ff @(posedge clk) begin
    j1  <= issue[IDX_W-1:0];
    j2  <= j1;
    sqx <= sqd(rd_data[3*COORD_BITS-1:2*COORD_BITS], cx);
    sqy <= sqd(rd_data[2*COORD_BITS-1:COORD_BITS], cy);
    sqz <= sqd(rd_data[COORD_BITS-1:0], cz);
    j3  <= j2;
    dsum <= sqx + sqy + sqz;
  end

  // strict compare keeps lower index first on ties
  always_comb begin
    for (int i = 0; i < MAX_STENCIL; i++) begin
      lt[i] = (K_W'(i) < filled) && (dsum < bdist[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && state == S_SCAN) begin
      for (int i = 0; i < MAX_STENCIL; i++) begin
        if (K_W'(i) < k) begin
          if (lt[i] && (i == 0 || !lt[(i == 0) ? 0 : i-1])) begin
            bdist[i] <= dsum;
            bnode[i] <= j3;
          end else if (i > 0 && lt[(i == 0) ? 0 : i-1]) begin
            bdist[i] <= bdist[(i == 0) ? 0 : i-1];
            bnode[i] <= bnode[(i == 0) ? 0 : i-1];
          end else if (K_W'(i) == filled) begin
            bdist[i] <= dsum;
            bnode[i] <= j3;
          end
        end
      end
    end
  end

  always_comb begin
    o_push = 1'b0;
    o_rank = '0;
    o_node = '0;
    o_dist = '0;
    o_stat = ST_OK;
    o_last = 1'b1;
    if (oq_used != 2'd2 || o_pop) begin
      if (state == S_ERR) begin
        o_push = 1'b1;
        o_stat = cmd_status_q;
      end else if (state == S_EMIT) begin
        o_push = 1'b1;
        o_rank = RANK_W'(emit_r);
        o_node = NODE_W'(bnode[emit_r[$clog2(MAX_STENCIL > 1 ? MAX_STENCIL : 2)-1:0]]);
        o_dist = DIST_W'(bdist[emit_r[$clog2(MAX_STENCIL > 1 ? MAX_STENCIL : 2)-1:0]]);
        o_last = (emit_r + 1'b1 == filled);
      end
    end
  end

  assign o_pop = pop && oq_used != 2'd0;
  assign empty = oq_used == 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_used <= '0;
    end else begin
      oq_used <= oq_used + {1'b0, o_push} - {1'b0, o_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (o_pop) begin
      oq_rank[0] <= oq_rank[1];
      oq_node[0] <= oq_node[1];
      oq_dist[0] <= oq_dist[1];
      oq_stat[0] <= oq_stat[1];
      oq_last[0] <= oq_last[1];
    end
    if (o_push) begin
      if (oq_used == 2'd0 || (oq_used == 2'd1 && o_pop)) begin
        oq_rank[0] <= o_rank; oq_node[0] <= o_node; oq_dist[0] <= o_dist;
        oq_stat[0] <= o_stat; oq_last[0] <= o_last;
      end else begin
        oq_rank[1] <= o_rank; oq_node[1] <= o_node; oq_dist[1] <= o_dist;
        oq_stat[1] <= o_stat; oq_last[1] <= o_last;
      end
    end
  end

  assign neighbour_rank   = oq_rank[0];
  assign neighbour_node   = oq_node[0];
  assign squared_distance = oq_dist[0];
  assign status           = oq_stat[0];
  assign last             = oq_last[0];

endmodule

/* hdl/k_nearest_stencil_select.sv */
// ----------------------------------------------------------------------------
// k_nearest_stencil_select
// Once a query is accepted, the back end reads its center, scans the store
// one node per cycle and drains its pipeline, then emits one result per cycle
// (up to 32) while the two-entry output queue has room; an error query gets
// one result. Throughput: clear/append one per cycle while full is low; full
// stays set from a query's acceptance until its last result is queued.
// Reset: node count cleared, stencil length 16, queues empty; no clearing pass.
// ----------------------------------------------------------------------------
module k_nearest_stencil_select
  import kns_pkg::*;
#(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int MAX_STENCIL = MAX_STENCIL_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [ACTION_W-1:0]          action,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  input  logic [NODE_W-1:0]            query_node,
  output logic                         empty,
  input  logic                         pop,
  output logic [RANK_W-1:0]            neighbour_rank,
  output logic [NODE_W-1:0]            neighbour_node,
  output logic [DIST_W-1:0]            squared_distance,
  output logic [STATUS_W-1:0]          status,
  output logic                         last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_W-1:0]             cfg_data
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);

  logic [CFG_W-1:0]        stencil_len;
  logic                    cmd_valid;
  cmd_t                    cmd_kind;
  logic [STATUS_W-1:0]     cmd_status;
  logic [IDX_W-1:0]        cmd_center;
  logic [CNT_W-1:0]        cmd_count;
  logic                    cmd_pop;
  logic                    back_busy;
  logic [IDX_W-1:0]        rd_addr;
  logic [3*COORD_BITS-1:0] rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stencil_len <= STENCIL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      stencil_len <= cfg_data;
    end
  end

  kns_front #(.MAX_NODES(MAX_NODES), .COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst, .push, .full, .action, .coord_x, .coord_y, .coord_z,
    .query_node, .cmd_valid, .cmd_kind, .cmd_status, .cmd_center,
    .cmd_count, .cmd_pop, .back_busy, .rd_addr, .rd_data
  );

  kns_back #(.MAX_NODES(MAX_NODES), .MAX_STENCIL(MAX_STENCIL),
             .COORD_BITS(COORD_BITS)) u_back (
    .clk, .rst, .stencil_len, .cmd_valid, .cmd_kind, .cmd_status,
    .cmd_center, .cmd_count, .cmd_pop, .back_busy, .rd_addr, .rd_data, .empty,
    .pop, .neighbour_rank, .neighbour_node, .squared_distance, .status, .last
  );

endmodule
